// ===== hdl/fir_lowpass_32tap_assert.svh =====
// Assertion helpers used by the filter top level.
`ifndef FIR_LOWPASS_32TAP_ASSERT_SVH
`define FIR_LOWPASS_32TAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fir_lp_pkg.sv =====
package fir_lp_pkg;

  localparam int DIG_W     = 4;   // bits of a sample consumed per cycle
  localparam int COEF_W    = 16;  // signed Q1.15 coefficients
  localparam int OUT_W     = 28;  // filter result width
  localparam int ROM_LEN   = 32;
  localparam int ROM_IDX_W = 5;
  localparam int TAP_IDX_W = 8;   // enough for the largest tap count

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  // Delay line control
  typedef struct packed {
    logic shift_in;
    logic clear;
    logic rotate;
  } dl_ctrl_t;

  // Digit-serial multiply-accumulate control
  typedef struct packed {
    logic start;      // clear accumulator
    logic load;       // load next tap word into the digit shifter
    logic step;       // consume one digit
    logic first_dig;  // most significant (signed) digit
    logic last_dig;   // least significant digit, product complete
  } mac_ctrl_t;

  // Symmetric low-pass design, rounded to nearest in Q1.15
  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
    -16'sd20,   -16'sd183,  -16'sd424,  -16'sd631,
    -16'sd578,  -16'sd141,   16'sd512,   16'sd923,
     16'sd623,  -16'sd423,  -16'sd1582, -16'sd1786,
    -16'sd212,   16'sd3038,  16'sd6764,  16'sd9248,
     16'sd9248,  16'sd6764,  16'sd3038, -16'sd212,
    -16'sd1786, -16'sd1582, -16'sd423,   16'sd623,
     16'sd923,   16'sd512,  -16'sd141,  -16'sd578,
    -16'sd631,  -16'sd424,  -16'sd183,  -16'sd20
  };

  // Taps past the end of the ROM weigh zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (idx < TAP_IDX_W'(ROM_LEN)) begin
      c = COEF_ROM[idx[ROM_IDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

// ===== hdl/fir_lp_delay.sv =====
module fir_lp_delay #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fir_lp_pkg::dl_ctrl_t      ctrl_i,
  input  logic [SAMPLE_BITS-1:0]    sample_i,
  output logic [SAMPLE_BITS-1:0]    head_o
);
  import fir_lp_pkg::*;

  logic [SAMPLE_BITS-1:0] dl_q [TAPS];
  logic [SAMPLE_BITS-1:0] dl_d [TAPS];

  // Clear the line, shift a new sample in at the head, or rotate toward the head so each
  // tap passes the read point once per item.
  always_comb begin
    dl_d = dl_q;
    if (ctrl_i.clear) begin
      for (int k = 0; k < TAPS; k++) begin
        dl_d[k] = '0;
      end
    end else if (ctrl_i.shift_in) begin
      dl_d[0] = sample_i;
      for (int k = 1; k < TAPS; k++) begin
        dl_d[k] = dl_q[k-1];
      end
    end else if (ctrl_i.rotate) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        dl_d[k] = dl_q[k+1];
      end
      dl_d[TAPS-1] = dl_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        dl_q[k] <= '0;
      end
    end else begin
      dl_q <= dl_d;
    end
  end

  assign head_o = dl_q[0];

endmodule

// ===== hdl/fir_lp_mac.sv =====
module fir_lp_mac #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_lp_pkg::mac_ctrl_t                  ctrl_i,
  input  logic [SAMPLE_BITS-1:0]                 head_i,
  input  logic signed [fir_lp_pkg::COEF_W-1:0]   coef_i,
  output logic [fir_lp_pkg::OUT_W-1:0]           acc_o
);
  import fir_lp_pkg::*;

  localparam int NDIG   = (SAMPLE_BITS + DIG_W - 1) / DIG_W;
  localparam int SREG_W = NDIG * DIG_W;

  logic [SREG_W-1:0]               sreg_q, sreg_d;
  logic [DIG_W-1:0]                digit;
  logic signed [DIG_W:0]           digit_s;
  logic signed [COEF_W+DIG_W:0]    prod;
  logic signed [OUT_W-1:0]         p_base;
  logic signed [OUT_W-1:0]         p_q, p_d;
  logic                            pv_q, pv_d;
  logic [OUT_W-1:0]                acc_q, acc_d;

  // Most significant digit first; only that digit carries the sign.
  assign digit   = sreg_q[SREG_W-1 -: DIG_W];
  assign digit_s = ctrl_i.first_dig ? {digit[DIG_W-1], digit} : {1'b0, digit};
  assign prod    = coef_i * digit_s;

  always_comb begin
    p_base = ctrl_i.first_dig ? '0 : (p_q <<< DIG_W);
    p_d    = ctrl_i.step ? (p_base + OUT_W'(prod)) : p_q;

    if (ctrl_i.load) begin
      sreg_d = SREG_W'(signed'(head_i));
    end else if (ctrl_i.step) begin
      sreg_d = sreg_q << DIG_W;
    end else begin
      sreg_d = sreg_q;
    end

    pv_d = ctrl_i.step && ctrl_i.last_dig;

    // Add the finished tap product in the cycle after it completes
    if (ctrl_i.start) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_q + p_q;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
    p_q    <= p_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/fir_lowpass_32tap.sv =====
// Low-pass FIR filter, direct form, TAPS taps (32 by default) with a fixed
// symmetric Q1.15 coefficient ROM; taps past the 32 ROM entries weigh zero.
// Each input transfer with tuser = 0 carries one raw unsigned converter
// sample; the block removes the mid-scale bias, shifts the centered sample
// into the delay line and returns one output transfer holding the centered
// sample and the exact 28-bit dot product (LSB units, 15 fraction bits,
// wraps rather than saturates). An input transfer with tuser = 1 zeroes the
// delay line and returns nothing. One digit-serial multiply-accumulate does
// all the work: a 4-bit digit of one tap per cycle, most significant digit
// first, so a filter item holds the block through the load, run, flush and
// output states before the next transfer is accepted, and it leaves the
// output state only once the output register is free; a finished result
// waits in the output register while the next sample is accepted. The delay
// line resets to all zeros.
`include "fir_lowpass_32tap_assert.svh"

module fir_lowpass_32tap #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Input stream
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // [SAMPLE_BITS-1:0] adc_sample, upper bits zero
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    s_axis_tdata_i,
  // [0] opcode
  input  logic                                        s_axis_tuser_i,
  // Output stream
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // [SAMPLE_BITS-1:0] centered_sample, then 28 bits filtered, upper bits zero
  output logic [((SAMPLE_BITS + fir_lp_pkg::OUT_W + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);
  import fir_lp_pkg::*;

  localparam int NDIG        = (SAMPLE_BITS + DIG_W - 1) / DIG_W;
  localparam int DIG_CNT_W   = $clog2(NDIG);
  localparam int TAP_W       = $clog2(TAPS);
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + OUT_W + 7) / 8) * 8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_RUN   = 5'b00100,
    S_FLUSH = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [TAP_W-1:0]        tap_cnt_q, tap_cnt_d;
  logic [DIG_CNT_W-1:0]    dig_cnt_q, dig_cnt_d;
  logic                    m_tvalid_q, m_tvalid_d;
  logic [SAMPLE_BITS-1:0]  cen_q, cen_d;
  logic [SAMPLE_BITS-1:0]  out_cen_q, out_cen_d;
  logic [OUT_W-1:0]        out_filt_q, out_filt_d;

  logic                    in_xfer;
  logic                    out_free;
  logic                    last_dig;
  logic                    last_tap;
  logic                    running;
  opcode_e                 op;
  logic [SAMPLE_BITS-1:0]  centered;
  logic [SAMPLE_BITS-1:0]  head;
  logic signed [COEF_W-1:0] coef;
  logic [OUT_W-1:0]        acc;
  dl_ctrl_t                dl_ctrl;
  mac_ctrl_t               mac_ctrl;

  // Accept input only between items; the output register is separate.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = opcode_e'(s_axis_tuser_i);

  // Subtracting the mid-scale bias is an inversion of the top bit.
  assign centered = {~s_axis_tdata_i[SAMPLE_BITS-1], s_axis_tdata_i[SAMPLE_BITS-2:0]};

  assign running  = (state_q == S_RUN);
  assign last_dig = (dig_cnt_q == DIG_CNT_W'(NDIG - 1));
  assign last_tap = (tap_cnt_q == TAP_W'(TAPS - 1));
  assign out_free = !m_tvalid_q || m_axis_tready_i;
  assign coef     = coef_at(TAP_IDX_W'(tap_cnt_q));

  // Delay line: new sample in on a filter transfer, rotate once per tap so
  // the line is back in place after the last tap.
  always_comb begin
    dl_ctrl.shift_in = in_xfer && (op == OP_FILTER);
    dl_ctrl.clear    = in_xfer && (op == OP_CLEAR);
    dl_ctrl.rotate   = (state_q == S_LOAD) || (running && last_dig && !last_tap);
  end

  always_comb begin
    mac_ctrl.start     = (state_q == S_LOAD);
    mac_ctrl.load      = (state_q == S_LOAD) || (running && last_dig && !last_tap);
    mac_ctrl.step      = running;
    mac_ctrl.first_dig = (dig_cnt_q == '0);
    mac_ctrl.last_dig  = last_dig;
  end

  always_comb begin
    state_d    = state_q;
    tap_cnt_d  = tap_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    cen_d      = cen_q;
    out_cen_d  = out_cen_q;
    out_filt_d = out_filt_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready_i;

    case (state_q)
      S_IDLE: begin
        if (in_xfer && (op == OP_FILTER)) begin
          cen_d   = centered;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        tap_cnt_d = '0;
        dig_cnt_d = '0;
        state_d   = S_RUN;
      end
      S_RUN: begin
        if (last_dig) begin
          dig_cnt_d = '0;
          tap_cnt_d = tap_cnt_q + 1'b1;
          if (last_tap) begin
            state_d = S_FLUSH;
          end
        end else begin
          dig_cnt_d = dig_cnt_q + 1'b1;
        end
      end
      S_FLUSH: begin
        // Last tap product lands in the accumulator this cycle
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_cen_d  = cen_q;
          out_filt_d = acc;
          m_tvalid_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tap_cnt_q  <= '0;
      dig_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tap_cnt_q  <= tap_cnt_d;
      dig_cnt_q  <= dig_cnt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cen_q      <= cen_d;
    out_cen_q  <= out_cen_d;
    out_filt_q <= out_filt_d;
  end

  fir_lp_delay #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_delay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dl_ctrl),
    .sample_i (centered),
    .head_o   (head)
  );

  fir_lp_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .head_i (head),
    .coef_i (coef),
    .acc_o  (acc)
  );

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_filt_q, out_cen_q});

  // The sum is flushed only after the last tap has gone through the MAC.
  `FLP_ASSERT_IMP(a_flush_after_last_tap, clk_i, rst_ni, state_q == S_FLUSH, $past(tap_cnt_q) == TAP_W'(TAPS - 1), "flush before last tap")

  // A clear transfer never starts a computation.
  `FLP_ASSERT_NXT(a_clear_stays_idle, clk_i, rst_ni, in_xfer && (op == OP_CLEAR), state_q == S_IDLE, "clear started a computation")

  // Between taps the digit counter wraps and the MAC keeps running.
  `FLP_ASSERT_NXT(a_digit_wrap, clk_i, rst_ni, running && last_dig && !last_tap, running && (dig_cnt_q == '0), "digit counter did not wrap")

endmodule
